### rtl/awbs_pkg.sv
// shared types and constants for the affine warp bilinear sampler
// no dependencies
package awbs_pkg;

  localparam int unsigned SrcMaxWidth  = 256;
  localparam int unsigned SrcMaxHeight = 256;
  localparam int unsigned PixelBits    = 16;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned ColBits      = $clog2(SrcMaxWidth);
  localparam int unsigned RowBits      = $clog2(SrcMaxHeight);
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 29;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_COEF_COS   = 3'd0,
    REG_COEF_SIN   = 3'd1,
    REG_OFFSET_X   = 3'd2,
    REG_OFFSET_Y   = 3'd3,
    REG_SRC_WIDTH  = 3'd4,
    REG_SRC_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  src_col;
    logic [7:0]  src_row;
    logic [15:0] pixel_value;
    logic [7:0]  dst_col;
    logic [7:0]  dst_row;
  } req_t;

  typedef struct packed {
    logic [15:0] out_value;
    logic        in_bounds;
  } rsp_t;

endpackage

### rtl/affine_warp_bilinear_sampler.sv
// affine warp bilinear sampler top level: coordinate map, banked image store, blend
// depends on awbs_pkg
//
// Accepts one request per cycle and, with the output side ready, returns one result per
// cycle; a query's result runs through every stage and the output skid. The source image
// sits in four banks split by column and row parity, so the four neighbors of any point
// come out in one read. A load writes one pixel and gives no result; a query gives one.
// Loads and queries flow in order through the pipe, so a query sees all earlier loads.
// Every stage moves only when the stage after it is free; a two-entry skid buffer at the
// output lets the pipe keep going until both entries fill. Image content is undefined until
// written and no clearing pass runs. Configuration must be written only while the pipe
// is idle.
module affine_warp_bilinear_sampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [awbs_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [awbs_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  awbs_pkg::req_t                   req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output awbs_pkg::rsp_t                   rsp_o
);
  import awbs_pkg::*;

  // configuration registers
  logic signed [23:0] cos_q, sin_q;
  logic signed [28:0] ox_q, oy_q;
  logic [8:0]         w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 24'sd65536;
      sin_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      w_q   <= 9'd256;
      h_q   <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_COS:   cos_q <= cfg_data_i[23:0];
        REG_COEF_SIN:   sin_q <= cfg_data_i[23:0];
        REG_OFFSET_X:   ox_q  <= cfg_data_i;
        REG_OFFSET_Y:   oy_q  <= cfg_data_i;
        REG_SRC_WIDTH:  w_q   <= cfg_data_i[8:0];
        REG_SRC_HEIGHT: h_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // clamped limits, (dim-1) in pixels; zero or negative means no interior
  logic signed [9:0] wlim, hlim;
  always_comb begin
    wlim = (w_q > 9'(SrcMaxWidth))  ? 10'(SrcMaxWidth - 1)  : $signed({1'b0, w_q}) - 10'sd1;
    hlim = (h_q > 9'(SrcMaxHeight)) ? 10'(SrcMaxHeight - 1) : $signed({1'b0, h_q}) - 10'sd1;
  end

  // pipeline: s1 products, s2 sums, s3 bounds/addr, s4 mem read, s5 horiz mult,
  // s6 vert mult, s7 round
  localparam int unsigned NStg = 7;
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;
  logic            out_free;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || out_free;
    for (int i = NStg - 2; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end
  assign req_ready_o = adv[0];

  // stage 1: coefficient products
  logic               op1_q, op2_q;
  logic [7:0]         lc1_q, lr1_q, lc2_q, lr2_q;
  logic [15:0]        lp1_q, lp2_q;
  logic signed [32:0] cc1_q, sr1_q, sc1_q, cr1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      op1_q <= req_i.op;
      lc1_q <= req_i.src_col;
      lr1_q <= req_i.src_row;
      lp1_q <= req_i.pixel_value;
      cc1_q <= 33'(cos_q) * 33'($signed({1'b0, req_i.dst_col}));
      sr1_q <= 33'(sin_q) * 33'($signed({1'b0, req_i.dst_row}));
      sc1_q <= 33'(sin_q) * 33'($signed({1'b0, req_i.dst_col}));
      cr1_q <= 33'(cos_q) * 33'($signed({1'b0, req_i.dst_row}));
    end
  end

  // stage 2: mapped point
  logic signed [34:0] x2_q, y2_q;
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      op2_q <= op1_q;
      lc2_q <= lc1_q;
      lr2_q <= lr1_q;
      lp2_q <= lp1_q;
      x2_q  <= 35'(cc1_q) - 35'(sr1_q) + 35'(ox_q);
      y2_q  <= 35'(sc1_q) + 35'(cr1_q) + 35'(oy_q);
    end
  end

  // stage 3: interior test and bank addressing
  logic signed [18:0] xi, yi;
  logic               inb;
  assign xi  = x2_q[34:FracBits];
  assign yi  = y2_q[34:FracBits];
  assign inb = !x2_q[34] && !y2_q[34] && (xi < 19'(wlim)) && (yi < 19'(hlim));

  logic               op3_q, inb3_q, we3_q;
  logic [7:0]         xc3_q, yr3_q;
  logic [15:0]        t3_q, u3_q, lp3_q;
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      op3_q  <= op2_q;
      inb3_q <= inb;
      we3_q  <= (op2_q == OP_LOAD) && v_q[1];
      xc3_q  <= (op2_q == OP_LOAD) ? lc2_q : xi[7:0];
      yr3_q  <= (op2_q == OP_LOAD) ? lr2_q : yi[7:0];
      lp3_q  <= lp2_q;
      t3_q   <= x2_q[FracBits-1:0];
      u3_q   <= y2_q[FracBits-1:0];
    end
  end

  // stage 4: banked store, bank index = {row parity, col parity}
  logic [15:0] bank0 [SrcMaxWidth*SrcMaxHeight/4];
  logic [15:0] bank1 [SrcMaxWidth*SrcMaxHeight/4];
  logic [15:0] bank2 [SrcMaxWidth*SrcMaxHeight/4];
  logic [15:0] bank3 [SrcMaxWidth*SrcMaxHeight/4];

  // neighbor coordinates: even/odd column and row covering x1 and x1+1
  logic [6:0] ce, co, re, ro;
  assign co = xc3_q[7:1];
  assign ce = xc3_q[7:1] + 7'(xc3_q[0]);
  assign ro = yr3_q[7:1];
  assign re = yr3_q[7:1] + 7'(yr3_q[0]);

  logic [15:0] q0, q1, q2, q3;
  logic        wr_en;
  assign wr_en = we3_q && adv[3] && (op3_q == OP_LOAD);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case ({yr3_q[0], xc3_q[0]})
        2'b00: bank0[{yr3_q[7:1], xc3_q[7:1]}] <= lp3_q;
        2'b01: bank1[{yr3_q[7:1], xc3_q[7:1]}] <= lp3_q;
        2'b10: bank2[{yr3_q[7:1], xc3_q[7:1]}] <= lp3_q;
        default: bank3[{yr3_q[7:1], xc3_q[7:1]}] <= lp3_q;
      endcase
    end
    if (adv[3]) begin
      q0 <= bank0[{re, ce}];
      q1 <= bank1[{re, co}];
      q2 <= bank2[{ro, ce}];
      q3 <= bank3[{ro, co}];
    end
  end

  logic        op4_q, inb4_q, xp4_q, yp4_q;
  logic [15:0] t4_q, u4_q;
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      op4_q  <= op3_q;
      inb4_q <= inb3_q;
      xp4_q  <= xc3_q[0];
      yp4_q  <= yr3_q[0];
      t4_q   <= t3_q;
      u4_q   <= u3_q;
    end
  end

  // steer banks to z1 (x1,y1) z2 (x1+1,y1) z3 (x1+1,y1+1) z4 (x1,y1+1)
  logic [15:0] ev_l, ev_r, od_l, od_r, z1, z2, z3, z4;
  always_comb begin
    ev_l = xp4_q ? q1 : q0;
    ev_r = xp4_q ? q0 : q1;
    od_l = xp4_q ? q3 : q2;
    od_r = xp4_q ? q2 : q3;
    z1 = yp4_q ? od_l : ev_l;
    z2 = yp4_q ? od_r : ev_r;
    z4 = yp4_q ? ev_l : od_l;
    z3 = yp4_q ? ev_r : od_r;
  end

  // stage 5: horizontal blends, scaled by 2^16
  logic [16:0] tc;
  assign tc = 17'h10000 - 17'(t4_q);
  logic        op5_q, inb5_q;
  logic [15:0] u5_q;
  logic [32:0] a5_q, b5_q;
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      op5_q  <= op4_q;
      inb5_q <= inb4_q;
      u5_q   <= u4_q;
      a5_q   <= 33'(tc) * 33'(z1) + 33'(t4_q) * 33'(z2);
      b5_q   <= 33'(tc) * 33'(z4) + 33'(t4_q) * 33'(z3);
    end
  end

  // stage 6: vertical blend products
  logic [16:0] uc;
  assign uc = 17'h10000 - 17'(u5_q);
  logic        op6_q, inb6_q;
  logic [49:0] pa6_q, pb6_q;
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      op6_q  <= op5_q;
      inb6_q <= inb5_q;
      pa6_q  <= 50'(uc) * 50'(a5_q);
      pb6_q  <= 50'(u5_q) * 50'(b5_q);
    end
  end

  // stage 7: sum, round half up
  logic [49:0] sum6;
  assign sum6 = pa6_q + pb6_q + 50'(64'h8000_0000);
  logic       op7_q;
  rsp_t       r7_q;
  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      op7_q            <= op6_q;
      r7_q.in_bounds   <= inb6_q;
      r7_q.out_value   <= inb6_q ? sum6[47:32] : '0;
    end
  end

  // valid bits; a load leaves the pipe after its store write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= req_valid_i;
      for (int i = 1; i < NStg; i++) begin
        if (adv[i]) v_q[i] <= (i == 4) ? (v_q[i-1] && op4_q) : v_q[i-1];
      end
    end
  end

  // output skid: two entries, input side sees only the registered fill count
  rsp_t       sk_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push, pop;
  assign push     = v_q[NStg-1] && out_free && op7_q;
  assign pop      = rsp_valid_o && rsp_ready_i;
  assign out_free = (cnt_q < 2'd2);
  assign rsp_valid_o = cnt_q != 2'd0;
  assign rsp_o       = sk_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) sk_q[wr_q] <= r7_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  // skid never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("skid overflow");
  // an out-of-bounds result is always zero
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.in_bounds |-> rsp_o.out_value == '0) else $error("nonzero outside");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o)) else $error("result changed");
`endif

endmodule
